>>> rtl/cbq_pkg.sv
// cbq_pkg: constants, types and helpers shared by the cascaded biquad equalizer
// no dependencies
`default_nettype none
package cbq_pkg;
    localparam int NUM_BANDS   = 8;
    localparam int COEF_FRAC   = 20;
    localparam int GAIN_FRAC   = 14;
    localparam int NUM_SLOTS   = 5;
    localparam int COEF_DEPTH  = NUM_BANDS * NUM_SLOTS;
    localparam int DELAY_DEPTH = NUM_BANDS * 4;
    localparam int CA_W        = $clog2(COEF_DEPTH);
    localparam int DA_W        = $clog2(DELAY_DEPTH);
    localparam int BAND_W      = $clog2(NUM_BANDS + 1);
    localparam logic [31:0] IDENTITY_B0 = 32'h0010_0000;
    localparam logic signed [23:0] SAT24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAT24_MIN = -24'sh800000;

    localparam logic [2:0] SLOT_A1 = 3'd0;
    localparam logic [2:0] SLOT_A2 = 3'd1;
    localparam logic [2:0] SLOT_B0 = 3'd2;
    localparam logic [2:0] SLOT_B1 = 3'd3;
    localparam logic [2:0] SLOT_B2 = 3'd4;

    localparam logic [1:0] CFG_EQ_ON  = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_BANDS  = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    typedef struct packed {
        logic       op;
        logic       channel;
        logic [23:0] sample_in;
        logic [2:0] band;
        logic [2:0] coef_slot;
        logic [31:0] coef_value;
    } item_t;

    function automatic logic [23:0] sat24(input logic [31:0] v);
        logic signed [31:0] s;
        begin
            s = v;
            if (s > 32'(SAT24_MAX)) sat24 = SAT24_MAX;
            else if (s < 32'(SAT24_MIN)) sat24 = SAT24_MIN;
            else sat24 = v[23:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/cbq_mac.sv
// cbq_mac: registered 32x32 signed multiply, 64-bit product
// depends on cbq_pkg
`default_nettype none
module cbq_mac
    import cbq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [63:0]      p_reg
);
    logic signed [63:0] p_next;
    // operands widen to 64 bits with sign before the multiply
    assign p_next = $signed(a) * $signed(b);
    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end
endmodule
`default_nettype wire

>>> rtl/cascaded_biquad_equalizer_top.sv
// cascaded_biquad_equalizer_top: stereo biquad cascade with error feedback
// depends on cbq_pkg, cbq_mac
//
// channel | direction | contents
// s_axis  | in        | op, channel, sample, band, slot, coef (tdata/tuser)
// m_axis  | out       | sample_out in tdata, channel_out in tuser
// cfg     | in        | eq_on, pre_gain, active_bands
//
// a sample steps through gain, gw, then b0, b1, b2, y, a1, a2, fin per band, and out
// (gw goes straight to fin with no bands; straight to out when disabled), set by one
// shared multiplier and single-port reads of the coefficient and delay memories. after
// reset a clearing pass loads the identity coefficients while no word is accepted;
// the delay memory clears in the same pass. a held result does not block the next
// word; the next result waits in the last state until the held one is taken.
`default_nettype none
module cascaded_biquad_equalizer_top
    import cbq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // sample_in[23:0], band[26:24], coef_slot[29:27],
                                       // coef_value[61:30], zeros
    input  wire logic [1:0]  s_tuser,  // op[0], channel[1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // sample_out[23:0]
    output logic             m_tuser,  // channel_out[0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_GAIN = 4'd2;
    localparam logic [3:0] ST_GW   = 4'd3;
    localparam logic [3:0] ST_B0   = 4'd4;
    localparam logic [3:0] ST_B1   = 4'd5;
    localparam logic [3:0] ST_B2   = 4'd6;
    localparam logic [3:0] ST_A1   = 4'd7;
    localparam logic [3:0] ST_A2   = 4'd8;
    localparam logic [3:0] ST_Y    = 4'd9;
    localparam logic [3:0] ST_FIN  = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    logic [31:0] coef_mem [COEF_DEPTH];
    logic [63:0] delay_mem [DELAY_DEPTH];

    logic [3:0]  state_reg, state_next;
    logic [CA_W-1:0] clr_reg;
    logic [2:0]  clr_slot_reg;
    logic        eq_on_reg;
    logic [15:0] gain_reg;
    logic [3:0]  bands_reg;
    logic [BAND_W-1:0] nb_reg, f_reg;
    logic        ch_reg;
    logic [31:0] x_reg;
    logic [63:0] s0_reg, d0_reg, d1_reg;
    logic [31:0] y_reg;
    logic [31:0] c_rd_reg;
    logic [63:0] d_rd_reg;
    logic        mv_reg;
    logic [23:0] mdata_reg;
    logic        mch_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    cbq_mac u_mac (.aclk(aclk), .a(mul_a), .b(mul_b), .p_reg(prod));

    item_t it;
    assign it.op = s_tuser[0];
    assign it.channel = s_tuser[1];
    assign it.sample_in = s_tdata[23:0];
    assign it.band = s_tdata[26:24];
    assign it.coef_slot = s_tdata[29:27];
    assign it.coef_value = s_tdata[61:30];

    assign s_tready = (state_reg == ST_IDLE);
    logic acc;
    assign acc = s_tvalid && s_tready;

    // result register is free or being emptied this cycle
    logic out_go;
    assign out_go = (state_reg == ST_OUT) && !(mv_reg && !m_tready);

    logic [CA_W-1:0] cbase;
    logic [DA_W-1:0] dbase;
    assign cbase = CA_W'(f_reg * NUM_SLOTS);
    assign dbase = DA_W'({f_reg, ch_reg, 1'b0});

    // read addresses chosen in the cycle before the read data is used
    logic [CA_W-1:0] c_ra;
    logic [DA_W-1:0] d_ra;
    always_comb begin
        c_ra = cbase + CA_W'(SLOT_B0);
        d_ra = dbase;
        case (state_reg)
            ST_B0: c_ra = cbase + CA_W'(SLOT_B1);
            ST_B1: begin c_ra = cbase + CA_W'(SLOT_B2); d_ra = dbase + DA_W'(1); end
            ST_Y:  c_ra = cbase + CA_W'(SLOT_A1);
            ST_A1: c_ra = cbase + CA_W'(SLOT_A2);
            default: ;
        endcase
    end

    // state ST_Y: y and e from s0
    logic [63:0] y64, e64;
    assign y64 = {{32{s0_reg[51]}}, s0_reg[51:20]};
    assign e64 = s0_reg - (y64 << COEF_FRAC);

    always_comb begin
        mul_a = x_reg;
        mul_b = c_rd_reg;
        case (state_reg)
            ST_GAIN: mul_b = {16'd0, gain_reg};
            ST_A1, ST_A2: mul_a = y_reg;
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:  if (clr_reg == CA_W'(COEF_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE: if (acc && it.op == OP_SAMPLE)
                         state_next = eq_on_reg ? ST_GAIN : ST_OUT;
            ST_GAIN: state_next = ST_GW;
            ST_GW:   state_next = (nb_reg == '0) ? ST_FIN : ST_B0;
            ST_B0:   state_next = ST_B1;
            ST_B1:   state_next = ST_B2;
            ST_B2:   state_next = ST_Y;
            ST_Y:    state_next = ST_A1;
            ST_A1:   state_next = ST_A2;
            ST_A2:   state_next = ST_FIN;
            ST_FIN:  state_next = (f_reg == nb_reg) ? ST_OUT : ST_B0;
            ST_OUT:  state_next = out_go ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        c_rd_reg <= coef_mem[c_ra];
        d_rd_reg <= delay_mem[d_ra];
        if (state_reg == ST_CLR) begin
            coef_mem[clr_reg] <= (clr_slot_reg == SLOT_B0) ? IDENTITY_B0 : 32'd0;
            if (clr_reg < CA_W'(DELAY_DEPTH))
                delay_mem[DA_W'(clr_reg)] <= 64'd0;
        end else if (acc && it.op == OP_COEF && it.coef_slot < 3'(NUM_SLOTS)
                     && {1'b0, it.band} < 4'(NUM_BANDS)) begin
            coef_mem[CA_W'(it.band * NUM_SLOTS + it.coef_slot)] <= it.coef_value;
        end else if (state_reg == ST_A2) begin
            delay_mem[dbase] <= d0_reg + prod + (e64 << 1);
        end else if (state_reg == ST_FIN && f_reg != '0) begin
            delay_mem[dbase - DA_W'(3)] <= d1_reg + prod - e64;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            clr_slot_reg <= '0;
            eq_on_reg <= 1'b0;
            gain_reg <= 16'd16384;
            bands_reg <= '0;
            mv_reg <= 1'b0;
            f_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR) begin
                clr_reg <= clr_reg + CA_W'(1);
                clr_slot_reg <= (clr_slot_reg == 3'(NUM_SLOTS - 1)) ? 3'd0
                                                                    : clr_slot_reg + 3'd1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EQ_ON: eq_on_reg <= cfg_data[0];
                    CFG_GAIN:  gain_reg <= cfg_data;
                    CFG_BANDS: bands_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_go) mv_reg <= 1'b1;
            else if (m_tvalid && m_tready) mv_reg <= 1'b0;
            if (acc) begin
                ch_reg <= it.channel;
                x_reg <= {{8{it.sample_in[23]}}, it.sample_in};
                f_reg <= '0;
                nb_reg <= (bands_reg > 4'(NUM_BANDS)) ? BAND_W'(NUM_BANDS)
                                                      : BAND_W'(bands_reg);
            end
            case (state_reg)
                ST_GW: x_reg <= prod[45:14];
                ST_B1: s0_reg <= prod + d_rd_reg;
                ST_B2: d0_reg <= prod + d_rd_reg;
                ST_Y:  begin d1_reg <= prod; y_reg <= y64[31:0]; end
                ST_A2: f_reg <= f_reg + BAND_W'(1);
                ST_FIN: if (f_reg != '0 && nb_reg != '0) x_reg <= y_reg;
                ST_OUT: begin
                    if (out_go) begin
                        mch_reg <= ch_reg;
                        mdata_reg <= eq_on_reg ? sat24(x_reg) : x_reg[23:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mch_reg;

    // d1 write lands in ST_FIN after f has advanced; dbase-3 wraps to old band entry 1
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_band_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B0) |-> (f_reg < nb_reg)) else $error("band overrun");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && mv_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result overwritten");
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire
